@@ hw/rtl/fccw_pkg.sv @@
// fccw_pkg: constants, codes, types and helpers of the FAT cluster chain walker.
// Used by fccw_alu, fat_cluster_chain_walker and tb_top; depends on nothing.

package fccw_pkg;

	// FAT image geometry
	localparam int FAT_BYTES   = 131072;
	localparam int ADDR_W      = 17;
	localparam int BANK_DEPTH  = FAT_BYTES / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);

	// Entry width decision: count > FAT12_LIMIT  <=>  diff >= (FAT12_LIMIT + 1) * spc
	localparam int FAT12_LIMIT = 4080;
	localparam int SPC_W       = 8;
	localparam int MUL_STEPS   = SPC_W;
	localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
	localparam int ALU_W       = 22;

	localparam logic [15:0] END16 = 16'hfff8;
	localparam logic [11:0] END12 = 12'hff8;

	// Input opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_TOTAL    = 2'd0;
	localparam logic [1:0] CFG_RESERVED = 2'd1;
	localparam logic [1:0] CFG_SYSTEM   = 2'd2;
	localparam logic [1:0] CFG_SPC      = 2'd3;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [ALU_W-1:0]   a;
		logic [ALU_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0]   sum;
		logic               neg;
	} alu_rsp_t;

	// End-of-chain marker test for the selected entry width
	function automatic logic marks_end(input logic [15:0] value, input logic wide);
		logic res;
		if (wide) begin
			res = (value >= END16);
		end else begin
			res = (value[11:0] >= END12);
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/fccw_ram.sv @@
// fccw_ram: generic single write port, single read port RAM with registered read.
// Self-contained; sized by WIDTH and DEPTH.

module fccw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/fccw_alu.sv @@
// fccw_alu: shared add/subtract unit of the chain walker sequencer.
// Depends on fccw_pkg for the request and response types.

module fccw_alu import fccw_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W-1:0] sum;

	always_comb begin
		unique case (req.op)
			ALU_ADD: sum = req.a + req.b;
			ALU_SUB: sum = req.a - req.b;
			default: sum = req.a + req.b;
		endcase
	end

	// sign bit doubles as the "a < b" flag for subtraction
	assign rsp.sum = sum;
	assign rsp.neg = sum[ALU_W-1];

endmodule

@@ hw/rtl/fat_cluster_chain_walker.sv @@
// fat_cluster_chain_walker: top level, sequencer, FAT image banks and output register.
// Depends on fccw_pkg, fccw_alu and fccw_ram.

// The block keeps a 128 KiB FAT byte image and walks a FAT12 or FAT16
// cluster chain one link per input beat. A load beat (opcode 0) writes one
// image byte and gives no result. A start beat (opcode 1) derives the data
// cluster count from the volume geometry registers and picks 16-bit entries
// when that count exceeds 4080, using one shared add/subtract unit for two
// subtractions, an 8-step shift-and-add multiply of sectors per cluster by
// 4081 and a final compare, and it returns the start cluster. In a step beat
// (opcode 2) the shared unit forms the entry byte offset (2n, or n + n/2 for
// 12-bit entries), the image is read once through an even and an odd byte
// bank so both bytes of the entry arrive together, and the next cluster is
// returned. Once an end marker has been seen, steps return the last value
// again with is_end set. Only one beat is in work at a time; in_stall is
// high until the sequencer is back in its idle state, while a finished
// result may still sit in the output register. Configuration writes are
// taken only while idle. The image has no reset; reading bytes never
// loaded gives undefined entries.

module fat_cluster_chain_walker import fccw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] fat_address,
	input  logic [7:0]        fat_byte,
	input  logic [15:0]       first_cluster,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       cluster,
	output logic              is_end,
	output logic              is_fat16,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIFF1 = 3'd1;	// total - reserved
	localparam logic [2:0] S_DIFF2 = 3'd2;	// - system, clamp at zero
	localparam logic [2:0] S_MUL   = 3'd3;	// 4081 * sectors_per_cluster
	localparam logic [2:0] S_CMP   = 3'd4;	// diff >= product -> FAT16
	localparam logic [2:0] S_ADDR  = 3'd5;	// entry offset, issue image read
	localparam logic [2:0] S_DATA  = 3'd6;	// decode entry from read data
	localparam logic [2:0] S_EMIT  = 3'd7;	// hand result to output register

	localparam logic [ALU_W-1:0] MUL_BASE = ALU_W'(FAT12_LIMIT + 1);
	localparam logic [ADDR_W:0]  IMG_END  = (ADDR_W + 1)'(FAT_BYTES);

	logic [2:0]           state_q;

	// configuration registers
	logic [15:0]          total_q;
	logic [15:0]          reserved_q;
	logic [15:0]          system_q;
	logic [SPC_W-1:0]     spc_q;

	// walk state
	logic [15:0]          cur_q;
	logic                 wide_q;
	logic                 done_q;
	logic [15:0]          start_q;

	// arithmetic working registers
	logic [ALU_W-1:0]     acc_q;
	logic [ALU_W-1:0]     prod_q;
	logic [ALU_W-1:0]     mcand_q;
	logic [SPC_W-1:0]     mult_q;
	logic [MUL_CNT_W-1:0] cnt_q;

	// image read bookkeeping
	logic                 odd_q;
	logic                 lo_oob_q;
	logic                 hi_oob_q;

	// output register
	logic                 out_valid_q;
	logic [15:0]          cluster_q;
	logic                 is_end_q;
	logic                 is_fat16_q;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;

	logic                 in_fire;
	logic                 cfg_fire;
	logic                 out_free;
	logic                 load_ok;

	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W:0]      rd_addr_p1;
	logic [BANK_AW-1:0]   even_raddr;
	logic [BANK_AW-1:0]   odd_raddr;
	logic                 rd_en;
	logic [7:0]           even_rdata;
	logic [7:0]           odd_rdata;
	logic [7:0]           lo_byte;
	logic [7:0]           hi_byte;
	logic [15:0]          word;
	logic [15:0]          next_cluster;
	logic [SPC_W-1:0]     spc_eff;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_fire  = cfg_valid && cfg_ready;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign cluster   = cluster_q;
	assign is_end    = is_end_q;
	assign is_fat16  = is_fat16_q;

	// zero sectors per cluster divides by one
	assign spc_eff = (spc_q == '0) ? SPC_W'(1) : spc_q;

	// ---------------------------------------------------------------
	// Shared add/subtract unit: operands chosen by the sequencer state
	// ---------------------------------------------------------------
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		unique case (state_q)
			S_DIFF1: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'(total_q);
				alu_req.b  = ALU_W'(reserved_q);
			end
			S_DIFF2: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = ALU_W'(system_q);
			end
			S_MUL: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = prod_q;
				alu_req.b  = mult_q[0] ? mcand_q : '0;
			end
			S_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = prod_q;
			end
			S_ADDR: begin
				// 2n for 16-bit entries, n + n/2 for 12-bit entries
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(cur_q);
				alu_req.b  = wide_q ? ALU_W'(cur_q) : ALU_W'(cur_q >> 1);
			end
			default: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = '0;
				alu_req.b  = '0;
			end
		endcase
	end

	fccw_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// ---------------------------------------------------------------
	// FAT image: even and odd byte banks so a little-endian word at any
	// byte offset comes back in one read
	// ---------------------------------------------------------------
	assign load_ok    = in_fire && (opcode == OP_LOAD) && ({1'b0, fat_address} < IMG_END);
	assign rd_en      = (state_q == S_ADDR);
	assign rd_addr    = alu_rsp.sum[ADDR_W-1:0];
	assign rd_addr_p1 = {1'b0, rd_addr} + (ADDR_W + 1)'(1);
	// odd offset: low byte sits in the odd bank, high byte in the next even row
	assign odd_raddr  = rd_addr[BANK_AW:1];
	assign even_raddr = rd_addr[0] ? rd_addr_p1[BANK_AW:1] : rd_addr[BANK_AW:1];

	fccw_ram #(
		.WIDTH (8),
		.DEPTH (BANK_DEPTH)
	) u_even_bank (
		.clk   (clk),
		.we    (load_ok && !fat_address[0]),
		.waddr (fat_address[BANK_AW:1]),
		.wdata (fat_byte),
		.re    (rd_en),
		.raddr (even_raddr),
		.rdata (even_rdata)
	);

	fccw_ram #(
		.WIDTH (8),
		.DEPTH (BANK_DEPTH)
	) u_odd_bank (
		.clk   (clk),
		.we    (load_ok && fat_address[0]),
		.waddr (fat_address[BANK_AW:1]),
		.wdata (fat_byte),
		.re    (rd_en),
		.raddr (odd_raddr),
		.rdata (odd_rdata)
	);

	// Reassemble the entry word; bytes past the image end read as zero
	always_comb begin
		lo_byte = odd_q ? odd_rdata : even_rdata;
		hi_byte = odd_q ? even_rdata : odd_rdata;
		if (lo_oob_q) begin
			lo_byte = '0;
		end
		if (hi_oob_q) begin
			hi_byte = '0;
		end
		word = {hi_byte, lo_byte};
		if (wide_q) begin
			next_cluster = word;
		end else if (cur_q[0]) begin
			next_cluster = word >> 4;
		end else begin
			next_cluster = {4'h0, word[11:0]};
		end
	end

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			reserved_q <= '0;
			system_q   <= '0;
			spc_q      <= SPC_W'(1);
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_TOTAL:    total_q    <= cfg_data;
				CFG_RESERVED: reserved_q <= cfg_data;
				CFG_SYSTEM:   system_q   <= cfg_data;
				CFG_SPC:      spc_q      <= cfg_data[SPC_W-1:0];
				default:      total_q    <= total_q;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer and walk state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			wide_q  <= 1'b0;
			done_q  <= 1'b1;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						priority if (opcode == OP_START) begin
							state_q <= S_DIFF1;
						end else if (opcode == OP_STEP) begin
							// finished chain: repeat the end marker, no read
							state_q <= done_q ? S_EMIT : S_ADDR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIFF1: begin
					state_q <= S_DIFF2;
				end
				S_DIFF2: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + MUL_CNT_W'(1);
					if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					// diff >= 4081 * spc  <=>  cluster count > 4080
					wide_q  <= !alu_rsp.neg;
					cur_q   <= start_q;
					done_q  <= marks_end(start_q, !alu_rsp.neg);
					state_q <= S_EMIT;
				end
				S_ADDR: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					cur_q   <= next_cluster;
					done_q  <= marks_end(next_cluster, wide_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register has room
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Arithmetic and read working registers (no reset needed)
	always_ff @(posedge clk) begin
		if (in_fire && (opcode == OP_START)) begin
			start_q <= first_cluster;
		end
		if (state_q == S_DIFF1) begin
			acc_q <= alu_rsp.sum;
		end
		if (state_q == S_DIFF2) begin
			// negative data area counts as zero clusters
			acc_q   <= alu_rsp.neg ? '0 : alu_rsp.sum;
			prod_q  <= '0;
			mcand_q <= MUL_BASE;
			mult_q  <= spc_eff;
		end
		if (state_q == S_MUL) begin
			prod_q  <= alu_rsp.sum;
			mcand_q <= mcand_q << 1;
			mult_q  <= mult_q >> 1;
		end
		if (state_q == S_ADDR) begin
			odd_q    <= rd_addr[0];
			lo_oob_q <= ({1'b0, rd_addr} >= IMG_END);
			hi_oob_q <= (rd_addr_p1 >= IMG_END);
		end
	end

	// ---------------------------------------------------------------
	// Output register: decouples the result from the next input beat
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			cluster_q  <= cur_q;
			is_end_q   <= done_q;
			is_fat16_q <= wide_q;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_cmp_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_MUL))
		else $error("width compare reached without finishing the multiply");

	a_data_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> ($past(state_q) == S_ADDR))
		else $error("entry decode not aligned with the image read");

	a_done_step_skips_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (opcode == OP_STEP) && done_q) |=> (state_q == S_EMIT))
		else $error("step after chain end did not go straight to emit");

	a_live_result_not_marker: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && !is_end_q) |-> !marks_end(cluster_q, is_fat16_q))
		else $error("end marker emitted without is_end");

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking bench for fat_cluster_chain_walker; builds FAT12/FAT16 chains in the
// image, walks them with random idling and stalls, and checks every link against a predictor.
// Depends on fccw_pkg and the RTL of fat_cluster_chain_walker.
`timescale 1ns / 1ps

module tb_top import fccw_pkg::*;;

	// opcode 3 has no meaning; the block must swallow it without a result
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BEATS = 240;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic [15:0]       start;
	} beat_t;

	typedef struct packed {
		logic [15:0] cluster;
		logic        is_end;
		logic        is_fat16;
	} link_t;

	// one input beat together with the link it must produce, if any
	typedef struct {
		beat_t beat;
		bit    yields;
		link_t link;
	} planned_t;

	logic clk = 1'b0;
	logic arst_n;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        opcode = OP_LOAD;
	logic [ADDR_W-1:0] fat_address = '0;
	logic [7:0]        fat_byte = '0;
	logic [15:0]       first_cluster = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [15:0]       cluster;
	logic              is_end;
	logic              is_fat16;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = CFG_TOTAL;
	logic [15:0]       cfg_data = '0;

	fat_cluster_chain_walker DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.fat_address   (fat_address),
		.fat_byte      (fat_byte),
		.first_cluster (first_cluster),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cluster       (cluster),
		.is_end        (is_end),
		.is_fat16      (is_fat16),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: its own image, walk position and volume geometry.
	// The image marks which bytes were loaded so that no beat ever reads a
	// byte the block has never seen.
	// ---------------------------------------------------------------------
	bit [7:0]    fat_image [FAT_BYTES];
	bit          image_loaded [FAT_BYTES];
	logic [15:0] walk_cluster = '0;
	logic        walk_wide = 1'b0;
	logic        walk_done = 1'b1;
	logic [15:0] geo_total = '0;
	logic [15:0] geo_reserved = '0;
	logic [15:0] geo_system = '0;
	logic [7:0]  geo_spc = 8'd1;

	planned_t beats_pending [$];	// planned beats not yet on the bus
	link_t    links_due [$];	// links owed by accepted beats, oldest first
	planned_t on_bus;
	int       beats_made = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;

	function automatic logic at_chain_end(input logic [15:0] v, input logic wide);
		return wide ? (v >= END16) : (v[11:0] >= END12);
	endfunction

	// byte offset of the entry of cluster n: 2n for FAT16, n + n/2 for FAT12
	function automatic logic [ADDR_W-1:0] entry_offset(input logic [15:0] n, input logic wide);
		if (wide)
			return {n, 1'b0};
		return ADDR_W'(n) + ADDR_W'(n >> 1);
	endfunction

	// Advance the predictor by one beat; return 1 when the beat owes a link.
	function automatic bit follow_beat(input beat_t b, output link_t r);
		int diff;
		int div;
		logic [ADDR_W-1:0] off;
		logic [15:0] word;
		r = '0;
		case (b.op)
		OP_LOAD: begin
			fat_image[b.addr] = b.data;
			image_loaded[b.addr] = 1'b1;
			return 1'b0;
		end
		OP_START: begin
			// data clusters = (total - reserved - system) / spc, floor at zero
			diff = int'(geo_total) - int'(geo_reserved) - int'(geo_system);
			if (diff < 0)
				diff = 0;
			div = (geo_spc == 8'd0) ? 1 : int'(geo_spc);
			walk_wide = (diff / div) > FAT12_LIMIT;
			walk_cluster = b.start;
			walk_done = at_chain_end(b.start, walk_wide);
		end
		OP_STEP: begin
			// past the end the last value repeats and nothing is read
			if (!walk_done) begin
				off = entry_offset(walk_cluster, walk_wide);
				word = {fat_image[off + 1], fat_image[off]};
				if (walk_wide)
					walk_cluster = word;
				else if (walk_cluster[0])
					walk_cluster = {4'h0, word[15:4]};
				else
					walk_cluster = {4'h0, word[11:0]};
				walk_done = at_chain_end(walk_cluster, walk_wide);
			end
		end
		default: return 1'b0;
		endcase
		r.cluster = walk_cluster;
		r.is_end = walk_done;
		r.is_fat16 = walk_wide;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus planning. Every planned beat runs through the predictor at
	// once, so the planner always knows where the walk stands.
	// ---------------------------------------------------------------------
	task automatic push_beat(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [7:0] data, input logic [15:0] start);
		planned_t p;
		p.beat = '{op: op, addr: addr, data: data, start: start};
		p.yields = follow_beat(p.beat, p.link);
		beats_pending.push_back(p);
		if (op != OP_UNUSED)
			beats_made++;
	endtask

	task automatic push_load(input logic [ADDR_W-1:0] addr, input logic [7:0] data);
		push_beat(OP_LOAD, addr, data, 16'($urandom));
	endtask

	task automatic push_start(input logic [15:0] c);
		push_beat(OP_START, ADDR_W'($urandom), 8'($urandom), c);
	endtask

	// Load the entry of cluster n with value v at the current entry width.
	// A FAT12 entry shares a nibble with its neighbor; keep that nibble.
	task automatic set_entry(input logic [15:0] n, input logic [15:0] v);
		logic [ADDR_W-1:0] off;
		logic [7:0] lo;
		logic [7:0] hi;
		off = entry_offset(n, walk_wide);
		lo = fat_image[off];
		hi = fat_image[off + 1];
		if (walk_wide) begin
			lo = v[7:0];
			hi = v[15:8];
		end else if (!n[0]) begin
			lo = v[7:0];
			hi = {hi[7:4], v[11:8]};
		end else begin
			lo = {v[3:0], lo[3:0]};
			hi = v[11:4];
		end
		push_load(off, lo);
		push_load(off + 1'b1, hi);
	endtask

	// next link: an end marker now and then, often a small pool of clusters
	// so that chains revisit entries, the rest anywhere in the range
	function automatic logic [15:0] pick_next();
		int unsigned r;
		logic [15:0] v;
		r = $urandom_range(99);
		if (r < 18)
			v = walk_wide ? (END16 | 16'($urandom_range(7))) : {4'h0, END12 | 12'($urandom_range(7))};
		else if (r < 60)
			v = 16'($urandom_range(80, 2));
		else
			v = 16'($urandom);
		if (!walk_wide)
			v[15:12] = 4'h0;
		return v;
	endfunction

	function automatic logic [15:0] pick_start();
		int unsigned r;
		logic [15:0] c;
		r = $urandom_range(99);
		c = 16'($urandom);
		if (r < 6)
			c[15:3] = '1;
		else if (r < 12)
			c[11:3] = '1;
		else if (r < 60)
			c = 16'($urandom_range(80, 2));
		return c;
	endfunction

	// Step one link; load the entry first if the walk would touch an unloaded
	// byte, and sometimes rewrite a loaded one to vary the chains.
	task automatic push_step();
		logic [ADDR_W-1:0] off;
		if (!walk_done) begin
			off = entry_offset(walk_cluster, walk_wide);
			if (!image_loaded[off] || !image_loaded[off + 1] || $urandom_range(9) == 0)
				set_entry(walk_cluster, pick_next());
		end
		push_beat(OP_STEP, ADDR_W'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// Mostly whole walks (start, links up to the end, a few steps past it),
	// some cut short, plus stray loads, stray steps and unused opcodes.
	task automatic plan_traffic(input int count);
		int quota;
		int links;
		quota = beats_made + count;
		while (beats_made < quota) begin
			case ($urandom_range(9))
			0: push_load(ADDR_W'($urandom), 8'($urandom));
			1: push_beat(OP_UNUSED, ADDR_W'($urandom), 8'($urandom), 16'($urandom));
			2: push_step();
			default: begin
				push_start(pick_start());
				links = $urandom_range(14);
				while (links > 0 && !walk_done) begin
					push_step();
					links--;
				end
				repeat ($urandom_range(2)) push_step();
			end
			endcase
		end
	endtask

	// Write all four geometry registers back to back; valid stays high
	// across the burst so it is never dropped and raised in one step.
	task automatic write_geometry(input logic [15:0] total, input logic [15:0] rsv,
			input logic [15:0] sys, input logic [7:0] spc);
		logic [1:0] regs [4];
		logic [15:0] vals [4];
		regs = '{CFG_TOTAL, CFG_RESERVED, CFG_SYSTEM, CFG_SPC};
		vals = '{total, rsv, sys, {8'($urandom), spc}};
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		geo_total = total;
		geo_reserved = rsv;
		geo_system = sys;
		geo_spc = spc;
	endtask

	// Hold until every planned beat is on its way and every owed link has
	// come back, then give a trailing load time to finish.
	task automatic drain();
		while (beats_pending.size() != 0 || in_valid || links_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Driver: present the next planned beat once the bus is free, idling at
	// random. An accepted beat hands its owed link to links_due.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_LOAD;
			fat_address <= '0;
			fat_byte <= '0;
			first_cluster <= '0;
		end else begin
			if (in_valid && !in_stall && on_bus.yields)
				links_due.push_back(on_bus.link);
			if (!in_valid || !in_stall) begin
				if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = beats_pending.pop_front();
					opcode <= on_bus.beat.op;
					fat_address <= on_bus.beat.addr;
					fat_byte <= on_bus.beat.data;
					first_cluster <= on_bus.beat.start;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: stall at random and check each accepted link, field by
	// field, against the oldest one owed.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		link_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (links_due.size() == 0) begin
					$display("%0t: link %h end %b fat16 %b with no beat owing one",
						$time, cluster, is_end, is_fat16);
					mismatches++;
				end else begin
					want = links_due.pop_front();
					if (cluster !== want.cluster) begin
						$display("%0t: cluster expected %h got %h", $time, want.cluster, cluster);
						mismatches++;
					end
					if (is_end !== want.is_end) begin
						$display("%0t: is_end expected %b got %b", $time, want.is_end, is_end);
						mismatches++;
					end
					if (is_fat16 !== want.is_fat16) begin
						$display("%0t: is_fat16 expected %b got %b", $time, want.is_fat16,
							is_fat16);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// count cycles in which no beat moves on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Sequence: directed FAT12 beats on reset geometry, then phases that
	// each set a geometry and an idling mix and run random walks.
	// ---------------------------------------------------------------------
	initial begin
		logic [15:0] total;
		logic [15:0] rsv;
		logic [15:0] sys;
		logic [7:0] spc;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry gives zero clusters, so FAT12
		push_step();		// step before any start: cluster 0, end set
		push_beat(OP_UNUSED, '1, '1, '1);
		push_load('1, 8'hff);
		push_load('0, 8'h00);
		push_start(16'hffff);	// start on an end marker
		push_step();		// step after the end repeats the marker
		push_start(16'h1ff8);	// end marker with upper bits set
		push_start(16'd2);
		set_entry(16'd2, 16'd3);
		set_entry(16'd3, 16'h0fff);
		push_step();		// even entry
		push_step();		// odd entry, reaches the end
		push_step();
		push_start(16'h0ff7);	// one below the marker walks on
		set_entry(16'h0ff7, 16'h0000);
		push_step();
		push_step();
		drain();

		for (int p = 1; p <= 8; p++) begin
			case (p)
			1: begin total = 16'hffff; rsv = 0; sys = 0; spc = 8'd1; end
			2: begin total = 16'd4081; rsv = 0; sys = 0; spc = 8'd1; end	// just FAT16
			3: begin total = 16'd4100; rsv = 16'd10; sys = 16'd10; spc = 8'd1; end	// just FAT12
			4: begin total = 16'd100; rsv = 16'hffff; sys = 16'hffff; spc = 8'hff; end	// below zero
			5: begin total = 16'hffff; rsv = 16'd1000; sys = 16'd2000; spc = 8'd0; end	// divisor 1
			6: begin total = 16'hffff; rsv = 0; sys = 0; spc = 8'd128; end
			default: begin
				total = 16'($urandom);
				rsv = 16'($urandom_range(2000));
				sys = 16'($urandom_range(2000));
				spc = 8'($urandom_range(16, 1));
			end
			endcase
			write_geometry(total, rsv, sys, spc);
			@(negedge clk);
			case (p)
			2, 6: begin send_idle_pct = 67; stall_pct = 0; end
			3, 7: begin send_idle_pct = 0; stall_pct = 67; end
			4, 8: begin send_idle_pct = 36; stall_pct = 36; end
			default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			if (p == 1) begin
				push_start(16'hfff8);	// lowest FAT16 marker
				push_step();
				push_start(16'hfff7);
				set_entry(16'hfff7, 16'hffff);
				push_step();
				push_step();
				push_start(16'h0000);
				set_entry(16'h0000, 16'hfff7);
				push_step();
			end
			plan_traffic(PHASE_BEATS);
			drain();
		end

		if (mismatches == 0 && links_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
